// File: hw/rtl/ctlc_pkg.sv
package ctlc_pkg;

  localparam int TABLE_SLOTS_DEF = 32;
  localparam int COORD_BITS_DEF  = 12;
  localparam int ID_BITS_DEF     = 16;

  localparam int BOX_BITS       = 12;
  localparam int COORD_MAX_BITS = 14;
  localparam int AREA_BITS      = 24;
  localparam int RADIUS_BITS    = 26;
  localparam int LINE_BITS      = 13;
  localparam int COUNT_BITS     = 16;
  localparam int OUT_ID_BITS    = 16;
  localparam int PADDR_BITS     = 4;
  localparam int PDATA_BITS     = 32;

  localparam logic [AREA_BITS-1:0]   MIN_AREA_RST  = 24'd500;
  localparam logic [RADIUS_BITS-1:0] RADIUS_SQ_RST = 26'd19600;
  localparam logic [LINE_BITS-1:0]   DOWN_LINE_RST = 13'd1120;
  localparam logic [LINE_BITS-1:0]   UP_LINE_RST   = 13'd1140;

  typedef enum logic [1:0] {
    REG_MIN_AREA  = 2'd0,
    REG_RADIUS_SQ = 2'd1,
    REG_DOWN_LINE = 2'd2,
    REG_UP_LINE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [AREA_BITS-1:0]   min_area;
    logic [RADIUS_BITS-1:0] radius_sq;
    logic [LINE_BITS-1:0]   down_line;
    logic [LINE_BITS-1:0]   up_line;
  } cfg_t;

  typedef struct packed {
    logic found;
    logic nid_hit;
  } match_flags_t;

endpackage

// File: hw/rtl/centroid_tracker_line_counter_core.sv
// Steps: an item with a blob that passes the area test scans the old table, scans the new
// table and writes its entry, then, when it ends a frame, scans the new table once more; a
// frame end with no stored blob does only that last scan, and any other item none. busy is
// low in the strobe cycle, so the next item can be accepted then; no item is taken while
// busy. The single read port of the table memory sets this order of scans.
// Synchronous active-low reset clears valid bits, ids, counters and config; no clear pass.
module centroid_tracker_line_counter_core #(
  parameter int TABLE_SLOTS = ctlc_pkg::TABLE_SLOTS_DEF,
  parameter int COORD_BITS  = ctlc_pkg::COORD_BITS_DEF,
  parameter int ID_BITS     = ctlc_pkg::ID_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_has_blob,
  input  logic [ctlc_pkg::BOX_BITS-1:0]       in_box_x,
  input  logic [ctlc_pkg::BOX_BITS-1:0]       in_box_y,
  input  logic [ctlc_pkg::BOX_BITS-1:0]       in_box_w,
  input  logic [ctlc_pkg::BOX_BITS-1:0]       in_box_h,
  input  logic [ctlc_pkg::AREA_BITS-1:0]      in_blob_area,
  input  logic                                in_frame_end,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ctlc_pkg::PADDR_BITS-1:0]     paddr,
  input  logic [ctlc_pkg::PDATA_BITS-1:0]     pwdata,
  output logic [ctlc_pkg::PDATA_BITS-1:0]     prdata,
  output logic                                pready,
  output logic                                out_valid,
  output logic                                out_accepted,
  output logic                                out_matched,
  output logic [ctlc_pkg::OUT_ID_BITS-1:0]    out_object_id,
  output logic                                out_table_full,
  output logic                                out_frame_done,
  output logic [ctlc_pkg::COUNT_BITS-1:0]     out_down_count,
  output logic [ctlc_pkg::COUNT_BITS-1:0]     out_up_count,
  output logic [ctlc_pkg::COUNT_BITS-1:0]     out_total_count
);
  import ctlc_pkg::*;

  localparam int SW   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW   = COORD_BITS + 2;
  localparam int CNTW = SW + 2;
  localparam int CMPW = (CW > LINE_BITS) ? CW : LINE_BITS;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [CW-1:0]      cx;
    logic [CW-1:0]      cy;
    logic               link;     // id also lives in the previous frame's table
    logic [CW-1:0]      link_cy;  // that entry's centroid y
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_OLD, S_NEW, S_WRITE, S_FEND, S_DONE
  } state_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  cfg_t cfg;

  state_t                 state_r;
  logic [CNTW-1:0]        cnt_r;
  logic                   bank_r;
  logic [TABLE_SLOTS-1:0] valid_r [2];
  logic [CW-1:0]          cx_r, cy_r;
  logic                   fend_r;
  logic [ID_BITS-1:0]     next_id_r;
  logic [COUNT_BITS-1:0]  down_r, up_r, all_r;
  logic                   rd_act_r, rd_vld_r;
  logic [SW-1:0]          rd_idx_r;
  logic                   hit_r, free_r;
  logic [SW-1:0]          hit_slot_r, free_slot_r;
  logic                   res_acc_r, res_match_r, res_full_r;
  logic [OUT_ID_BITS-1:0] res_id_r;

  logic                   out_valid_r, out_acc_r, out_match_r, out_full_r, out_fdone_r;
  logic [OUT_ID_BITS-1:0] out_id_r;
  logic [COUNT_BITS-1:0]  out_down_r, out_up_r, out_all_r;

  // input side
  logic [COORD_MAX_BITS-1:0] bx_w, by_w, bw_w, bh_w;
  logic [CW-1:0]             cx_in, cy_in;
  logic                      blob_ok_in, accept;

  assign bx_w  = {{(COORD_MAX_BITS-BOX_BITS){1'b0}}, in_box_x};
  assign by_w  = {{(COORD_MAX_BITS-BOX_BITS){1'b0}}, in_box_y};
  assign bw_w  = {{(COORD_MAX_BITS-BOX_BITS){1'b0}}, in_box_w};
  assign bh_w  = {{(COORD_MAX_BITS-BOX_BITS){1'b0}}, in_box_h};
  assign cx_in = CW'({bx_w[COORD_BITS-1:0], 1'b0}) + CW'(bw_w[COORD_BITS-1:0]);
  assign cy_in = CW'({by_w[COORD_BITS-1:0], 1'b0}) + CW'(bh_w[COORD_BITS-1:0]);
  assign blob_ok_in = in_has_blob && (in_blob_area >= cfg.min_area);

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // table scan: read issued from cnt_r, data returned the cycle after, tagged by rd_*_r
  logic          scanning, issuing, issue_vld, rd_bank;
  logic [SW-1:0] cnt_idx;

  assign scanning  = (state_r == S_OLD) || (state_r == S_NEW) || (state_r == S_FEND);
  assign issuing   = scanning && (cnt_r < CNTW'(TABLE_SLOTS));
  assign cnt_idx   = cnt_r[SW-1:0];
  assign rd_bank   = (state_r == S_OLD) ? bank_r : ~bank_r;
  assign issue_vld = issuing && valid_r[rd_bank][cnt_idx];

  entry_t                   rd_ent, wr_ent;
  logic [$bits(entry_t)-1:0] mem_rdata;
  logic                     mem_we;
  logic [SW-1:0]            wr_slot;
  logic                     wr_ok, slot_taken;

  assign rd_ent = mem_rdata;

  // match unit
  match_flags_t       mflags;
  logic [ID_BITS-1:0] best_id, target_id;
  logic [CW-1:0]      best_cy, nid_cy;
  logic               m_valid;
  logic [31:0]        target_ext;

  assign m_valid    = rd_act_r && rd_vld_r && (state_r == S_OLD);
  assign target_id  = mflags.found ? best_id : next_id_r;
  assign target_ext = 32'(target_id);

  assign wr_ok          = hit_r || free_r;
  assign wr_slot        = hit_r ? hit_slot_r : free_slot_r;
  assign mem_we         = (state_r == S_WRITE) && wr_ok;
  assign slot_taken     = valid_r[~bank_r][wr_slot];
  assign wr_ent.id      = target_id;
  assign wr_ent.cx      = cx_r;
  assign wr_ent.cy      = cy_r;
  assign wr_ent.link    = mflags.found || mflags.nid_hit;
  assign wr_ent.link_cy = mflags.found ? best_cy : nid_cy;

  // frame end crossing test on each linked new entry
  logic                  fe_hit, x_dn, x_up;
  logic [CMPW-1:0]       old_y, new_y, dn_y, up_y;
  logic [COUNT_BITS-1:0] down_nxt, up_nxt, all_mid, all_nxt;

  assign fe_hit   = (state_r == S_FEND) && rd_act_r && rd_vld_r && rd_ent.link;
  assign old_y    = CMPW'(rd_ent.link_cy);
  assign new_y    = CMPW'(rd_ent.cy);
  assign dn_y     = CMPW'(cfg.down_line);
  assign up_y     = CMPW'(cfg.up_line);
  assign x_dn     = fe_hit && (old_y < dn_y) && (new_y >= dn_y);
  assign x_up     = fe_hit && (old_y > up_y) && (new_y <= up_y);
  assign down_nxt = x_dn ? sat_inc(down_r) : down_r;
  assign up_nxt   = x_up ? sat_inc(up_r) : up_r;
  assign all_mid  = x_dn ? sat_inc(all_r) : all_r;
  assign all_nxt  = x_up ? sat_inc(all_mid) : all_mid;

  ctlc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ctlc_mem #(
    .ADDR_BITS (SW + 1),
    .DATA_BITS ($bits(entry_t))
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({~bank_r, wr_slot}),
    .wdata (wr_ent),
    .raddr ({rd_bank, cnt_idx}),
    .rdata (mem_rdata)
  );

  ctlc_match #(
    .ID_BITS (ID_BITS),
    .CW      (CW)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (accept),
    .in_valid  (m_valid),
    .e_id      (rd_ent.id),
    .e_cx      (rd_ent.cx),
    .e_cy      (rd_ent.cy),
    .blob_cx   (cx_r),
    .blob_cy   (cy_r),
    .radius_sq (cfg.radius_sq),
    .next_id   (next_id_r),
    .flags     (mflags),
    .best_id   (best_id),
    .best_cy   (best_cy),
    .nid_cy    (nid_cy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      bank_r      <= 1'b0;
      valid_r[0]  <= '0;
      valid_r[1]  <= '0;
      next_id_r   <= '0;
      down_r      <= '0;
      up_r        <= '0;
      all_r       <= '0;
      rd_act_r    <= 1'b0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      fend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_act_r    <= issuing;
      rd_vld_r    <= issue_vld;
      rd_idx_r    <= cnt_idx;
      down_r      <= down_nxt;
      up_r        <= up_nxt;
      all_r       <= all_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cx_r        <= cx_in;
            cy_r        <= cy_in;
            fend_r      <= in_frame_end;
            cnt_r       <= '0;
            hit_r       <= 1'b0;
            free_r      <= 1'b0;
            res_acc_r   <= 1'b0;
            res_match_r <= 1'b0;
            res_full_r  <= 1'b0;
            res_id_r    <= '0;
            if (blob_ok_in) begin
              state_r <= S_OLD;
            end else if (in_frame_end) begin
              state_r <= S_FEND;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_OLD: begin
          // the count runs past the last slot to drain the memory read register and the match pipeline
          if (cnt_r == CNTW'(TABLE_SLOTS + 2)) begin
            cnt_r   <= '0;
            state_r <= S_NEW;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_NEW: begin
          if (rd_act_r) begin
            if (rd_vld_r && (rd_ent.id == target_id)) begin
              hit_r      <= 1'b1;
              hit_slot_r <= rd_idx_r;
            end
            if (!rd_vld_r && !free_r) begin
              free_r      <= 1'b1;
              free_slot_r <= rd_idx_r;
            end
          end
          if (cnt_r == CNTW'(TABLE_SLOTS)) begin
            state_r <= S_WRITE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_WRITE: begin
          cnt_r <= '0;
          if (wr_ok) begin
            valid_r[~bank_r][wr_slot] <= 1'b1;
            if (!mflags.found) begin
              next_id_r <= next_id_r + 1'b1;
            end
            res_acc_r   <= 1'b1;
            res_match_r <= mflags.found;
            res_id_r    <= target_ext[OUT_ID_BITS-1:0];
          end else begin
            res_full_r <= 1'b1;
          end
          state_r <= fend_r ? S_FEND : S_DONE;
        end
        S_FEND: begin
          if (cnt_r == CNTW'(TABLE_SLOTS)) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          out_acc_r   <= res_acc_r;
          out_match_r <= res_match_r;
          out_id_r    <= res_id_r;
          out_full_r  <= res_full_r;
          out_fdone_r <= fend_r;
          out_down_r  <= down_r;
          out_up_r    <= up_r;
          out_all_r   <= all_r;
          if (fend_r) begin
            // new table becomes old; the old bank is emptied for the next frame
            bank_r          <= ~bank_r;
            valid_r[bank_r] <= '0;
          end
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_matched     = out_match_r;
  assign out_object_id   = out_id_r;
  assign out_table_full  = out_full_r;
  assign out_frame_done  = out_fdone_r;
  assign out_down_count  = out_down_r;
  assign out_up_count    = out_up_r;
  assign out_total_count = out_all_r;

  a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_acc_r && out_full_r) && (out_acc_r || !out_match_r))
    else $error("inconsistent result flags");

  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && !hit_r) |-> !slot_taken)
    else $error("table write over a live entry without id hit");

  a_counters_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (down_r >= $past(down_r)) && (up_r >= $past(up_r)) && (all_r >= $past(all_r)))
    else $error("crossing counter decreased");

endmodule

// File: hw/rtl/ctlc_regs.sv
module ctlc_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ctlc_pkg::PADDR_BITS-1:0]     paddr,
  input  logic [ctlc_pkg::PDATA_BITS-1:0]     pwdata,
  output logic [ctlc_pkg::PDATA_BITS-1:0]     prdata,
  output logic                                pready,
  output ctlc_pkg::cfg_t                      cfg
);
  import ctlc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[PADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_area  <= MIN_AREA_RST;
      cfg_r.radius_sq <= RADIUS_SQ_RST;
      cfg_r.down_line <= DOWN_LINE_RST;
      cfg_r.up_line   <= UP_LINE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_AREA:  cfg_r.min_area  <= pwdata[AREA_BITS-1:0];
        REG_RADIUS_SQ: cfg_r.radius_sq <= pwdata[RADIUS_BITS-1:0];
        REG_DOWN_LINE: cfg_r.down_line <= pwdata[LINE_BITS-1:0];
        REG_UP_LINE:   cfg_r.up_line   <= pwdata[LINE_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_AREA:  prdata = PDATA_BITS'(cfg_r.min_area);
      REG_RADIUS_SQ: prdata = PDATA_BITS'(cfg_r.radius_sq);
      REG_DOWN_LINE: prdata = PDATA_BITS'(cfg_r.down_line);
      REG_UP_LINE:   prdata = PDATA_BITS'(cfg_r.up_line);
    endcase
  end

endmodule

// File: hw/rtl/ctlc_mem.sv
module ctlc_mem #(
  parameter int ADDR_BITS = 6,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem_r [2**ADDR_BITS];
  logic [DATA_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/ctlc_match.sv
module ctlc_match #(
  parameter int ID_BITS = 16,
  parameter int CW      = 14
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               clear,
  input  logic                               in_valid,
  input  logic [ID_BITS-1:0]                 e_id,
  input  logic [CW-1:0]                      e_cx,
  input  logic [CW-1:0]                      e_cy,
  input  logic [CW-1:0]                      blob_cx,
  input  logic [CW-1:0]                      blob_cy,
  input  logic [ctlc_pkg::RADIUS_BITS-1:0]   radius_sq,
  input  logic [ID_BITS-1:0]                 next_id,
  output ctlc_pkg::match_flags_t             flags,
  output logic [ID_BITS-1:0]                 best_id,
  output logic [CW-1:0]                      best_cy,
  output logic [CW-1:0]                      nid_cy
);
  import ctlc_pkg::*;

  localparam int SQW  = 2 * CW;
  localparam int SUMW = SQW + 1;
  localparam int RW   = (SUMW > RADIUS_BITS) ? SUMW : RADIUS_BITS;

  // stage 1: abs differences
  logic               v1_r, eq1_r;
  logic [CW-1:0]      dx1_r, dy1_r, cy1_r;
  logic [ID_BITS-1:0] id1_r;
  // stage 2: squares
  logic               v2_r, eq2_r;
  logic [SQW-1:0]     sqx2_r, sqy2_r;
  logic [CW-1:0]      cy2_r;
  logic [ID_BITS-1:0] id2_r;
  // stage 3: running best
  logic               found_r, nid_hit_r;
  logic [ID_BITS-1:0] best_id_r;
  logic [CW-1:0]      best_cy_r, nid_cy_r;

  logic [CW-1:0]   dx, dy;
  logic [SUMW-1:0] dist_sq;
  logic            near, take, nid_take;

  assign dx = (e_cx > blob_cx) ? (e_cx - blob_cx) : (blob_cx - e_cx);
  assign dy = (e_cy > blob_cy) ? (e_cy - blob_cy) : (blob_cy - e_cy);

  assign dist_sq  = SUMW'(sqx2_r) + SUMW'(sqy2_r);
  assign near     = RW'(dist_sq) < RW'(radius_sq);
  // smallest id wins among entries inside the radius
  assign take     = v2_r && near && (!found_r || (id2_r < best_id_r));
  assign nid_take = v2_r && eq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      found_r   <= 1'b0;
      nid_hit_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      if (clear) begin
        found_r   <= 1'b0;
        nid_hit_r <= 1'b0;
      end else begin
        if (take) begin
          found_r <= 1'b1;
        end
        if (nid_take) begin
          nid_hit_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dx1_r  <= dx;
    dy1_r  <= dy;
    cy1_r  <= e_cy;
    id1_r  <= e_id;
    eq1_r  <= (e_id == next_id);
    sqx2_r <= SQW'(dx1_r) * SQW'(dx1_r);
    sqy2_r <= SQW'(dy1_r) * SQW'(dy1_r);
    cy2_r  <= cy1_r;
    id2_r  <= id1_r;
    eq2_r  <= eq1_r;
    if (take) begin
      best_id_r <= id2_r;
      best_cy_r <= cy2_r;
    end
    if (nid_take) begin
      nid_cy_r <= cy2_r;
    end
  end

  assign flags.found   = found_r;
  assign flags.nid_hit = nid_hit_r;
  assign best_id       = best_id_r;
  assign best_cy       = best_cy_r;
  assign nid_cy        = nid_cy_r;

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  import ctlc_pkg::*;

  localparam int SLOTS = TABLE_SLOTS_DEF;
  localparam int N_DIRECTED = 15;
  localparam int N_PHASES = 7;
  localparam int MAX_CARS = 8;
  localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

  typedef struct packed {
    logic                 has_blob;
    logic [BOX_BITS-1:0]  box_x;
    logic [BOX_BITS-1:0]  box_y;
    logic [BOX_BITS-1:0]  box_w;
    logic [BOX_BITS-1:0]  box_h;
    logic [AREA_BITS-1:0] area;
    logic                 frame_end;
  } blob_item_t;

  typedef struct packed {
    logic                   accepted;
    logic                   matched;
    logic [OUT_ID_BITS-1:0] object_id;
    logic                   table_full;
    logic                   frame_done;
    logic [COUNT_BITS-1:0]  down_count;
    logic [COUNT_BITS-1:0]  up_count;
    logic [COUNT_BITS-1:0]  total_count;
  } track_result_t;

  typedef struct packed {
    blob_item_t    item;
    logic          typed;
    track_result_t want;
  } stim_row_t;

  typedef struct packed {
    logic [ID_BITS_DEF-1:0]    id;
    logic [COORD_MAX_BITS-1:0] cx;
    logic [COORD_MAX_BITS-1:0] cy;
  } track_entry_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_has_blob = 1'b0;
  logic [BOX_BITS-1:0]      in_box_x = '0;
  logic [BOX_BITS-1:0]      in_box_y = '0;
  logic [BOX_BITS-1:0]      in_box_w = '0;
  logic [BOX_BITS-1:0]      in_box_h = '0;
  logic [AREA_BITS-1:0]     in_blob_area = '0;
  logic                     in_frame_end = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_BITS-1:0]    paddr = '0;
  logic [PDATA_BITS-1:0]    pwdata = '0;
  logic [PDATA_BITS-1:0]    prdata;
  logic                     pready;
  logic                     out_valid;
  logic                     out_accepted;
  logic                     out_matched;
  logic [OUT_ID_BITS-1:0]   out_object_id;
  logic                     out_table_full;
  logic                     out_frame_done;
  logic [COUNT_BITS-1:0]    out_down_count;
  logic [COUNT_BITS-1:0]    out_up_count;
  logic [COUNT_BITS-1:0]    out_total_count;

  centroid_tracker_line_counter_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_has_blob(in_has_blob), .in_box_x(in_box_x), .in_box_y(in_box_y),
    .in_box_w(in_box_w), .in_box_h(in_box_h), .in_blob_area(in_blob_area),
    .in_frame_end(in_frame_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .out_valid(out_valid), .out_accepted(out_accepted), .out_matched(out_matched),
    .out_object_id(out_object_id), .out_table_full(out_table_full),
    .out_frame_done(out_frame_done), .out_down_count(out_down_count),
    .out_up_count(out_up_count), .out_total_count(out_total_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // tracker model state
  cfg_t                   track_cfg = '{MIN_AREA_RST, RADIUS_SQ_RST, DOWN_LINE_RST, UP_LINE_RST};
  bit                     prev_used [SLOTS];
  track_entry_t           prev_trk [SLOTS];
  bit                     cur_used [SLOTS];
  track_entry_t           cur_trk [SLOTS];
  logic [ID_BITS_DEF-1:0] fresh_id = '0;
  int                     down_tally = 0;
  int                     up_tally = 0;
  int                     all_tally = 0;

  track_result_t pending_results [$];
  track_result_t seen_want;
  int            n_mismatch = 0;
  int            n_counted = 0;
  int            idle_pct = 0;

  // synthetic traffic: cars in fixed lanes moving toward a line
  int n_cars;
  int car_cx [MAX_CARS];
  int car_cy [MAX_CARS];
  int car_v [MAX_CARS];
  bit car_down [MAX_CARS];

  // rows: has_blob, x, y, w, h, area, frame_end | typed | result
  stim_row_t directed_tab [N_DIRECTED] = '{
    // no blob, fields at max
    '{'{1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 24'hFFFFFF, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0}},
    // one below the area threshold
    '{'{1'b1, 12'd100, 12'd100, 12'd40, 12'd40, 24'd499, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0}},
    '{'{1'b1, 12'd0, 12'd0, 12'd0, 12'd0, 24'd500, 1'b0}, 1'b1,
      '{1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0}},
    '{'{1'b1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 24'hFFFFFF, 1'b0}, 1'b1,
      '{1'b1, 1'b0, 16'd1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0}},
    '{'{1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 24'd0, 1'b1}, 1'b1,
      '{1'b0, 1'b0, 16'd0, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0}},
    '{'{1'b1, 12'd10, 12'd10, 12'd0, 12'd0, 24'd500, 1'b0}, 1'b1,
      '{1'b1, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0}},
    '{'{1'b1, 12'd500, 12'd500, 12'd20, 12'd20, 24'd800, 1'b1}, 1'b0, '0},
    // lands exactly on the down line
    '{'{1'b1, 12'd500, 12'd550, 12'd20, 12'd20, 24'd800, 1'b1}, 1'b1,
      '{1'b1, 1'b1, 16'd2, 1'b0, 1'b1, 16'd1, 16'd0, 16'd1}},
    '{'{1'b1, 12'd500, 12'd580, 12'd20, 12'd20, 24'd800, 1'b1}, 1'b0, '0},
    '{'{1'b1, 12'd500, 12'd560, 12'd20, 12'd0, 24'd800, 1'b1}, 1'b1,
      '{1'b1, 1'b1, 16'd2, 1'b0, 1'b1, 16'd1, 16'd1, 16'd2}},
    // distance squared equal to the radius: no match
    '{'{1'b1, 12'd570, 12'd560, 12'd20, 12'd0, 24'd800, 1'b0}, 1'b0, '0},
    '{'{1'b1, 12'd570, 12'd560, 12'd19, 12'd0, 24'd800, 1'b0}, 1'b0, '0},
    // same id again in this frame overwrites its entry
    '{'{1'b1, 12'd510, 12'd560, 12'd0, 12'd0, 24'd800, 1'b1}, 1'b0, '0},
    // two candidates, smaller id sits in the later slot
    '{'{1'b1, 12'd535, 12'd560, 12'd20, 12'd0, 24'd800, 1'b0}, 1'b0, '0},
    '{'{1'b1, 12'd0, 12'd0, 12'd0, 12'd0, 24'd0, 1'b1}, 1'b0, '0}
  };

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  function automatic int find_cur(input logic [ID_BITS_DEF-1:0] id);
    int hit;
    hit = -1;
    for (int j = 0; j < SLOTS; j++)
      if (hit < 0 && cur_used[j] && cur_trk[j].id == id) hit = j;
    return hit;
  endfunction

  function automatic track_result_t predict_track(input blob_item_t it);
    track_result_t r;
    logic [COORD_MAX_BITS-1:0] cx, cy;
    longint dx, dy;
    bit found;
    logic [ID_BITS_DEF-1:0] id;
    int slot, hit;
    r = '0;
    if (it.has_blob && it.area >= track_cfg.min_area) begin
      cx = {1'b0, it.box_x, 1'b0} + COORD_MAX_BITS'(it.box_w);
      cy = {1'b0, it.box_y, 1'b0} + COORD_MAX_BITS'(it.box_h);
      found = 1'b0;
      id = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (prev_used[i]) begin
          dx = longint'(prev_trk[i].cx) - longint'(cx);
          dy = longint'(prev_trk[i].cy) - longint'(cy);
          if (dx * dx + dy * dy < longint'(track_cfg.radius_sq) &&
              (!found || prev_trk[i].id < id)) begin
            found = 1'b1;
            id = prev_trk[i].id;
          end
        end
      end
      if (!found) id = fresh_id;
      slot = find_cur(id);
      for (int i = 0; i < SLOTS; i++)
        if (slot < 0 && !cur_used[i]) slot = i;
      if (slot < 0) begin
        r.table_full = 1'b1;
      end else begin
        cur_used[slot] = 1'b1;
        cur_trk[slot] = '{id, cx, cy};
        if (!found) fresh_id++;
        r.accepted = 1'b1;
        r.matched = found;
        r.object_id = OUT_ID_BITS'(id);
      end
    end
    if (it.frame_end) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (prev_used[i]) begin
          hit = find_cur(prev_trk[i].id);
          if (hit >= 0) begin
            if (prev_trk[i].cy < track_cfg.down_line && cur_trk[hit].cy >= track_cfg.down_line) begin
              if (down_tally < 65535) down_tally++;
              if (all_tally < 65535) all_tally++;
            end
            if (prev_trk[i].cy > track_cfg.up_line && cur_trk[hit].cy <= track_cfg.up_line) begin
              if (up_tally < 65535) up_tally++;
              if (all_tally < 65535) all_tally++;
            end
          end
        end
      end
      prev_used = cur_used;
      prev_trk = cur_trk;
      foreach (cur_used[j]) cur_used[j] = 1'b0;
    end
    r.frame_done = it.frame_end;
    r.down_count = COUNT_BITS'(down_tally);
    r.up_count = COUNT_BITS'(up_tally);
    r.total_count = COUNT_BITS'(all_tally);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("result transfer with nothing expected: id %0d", out_object_id);
      end else begin
        seen_want = pending_results.pop_front();
        check_field("accepted", seen_want.accepted, out_accepted);
        check_field("matched", seen_want.matched, out_matched);
        check_field("object_id", seen_want.object_id, out_object_id);
        check_field("table_full", seen_want.table_full, out_table_full);
        check_field("frame_done", seen_want.frame_done, out_frame_done);
        check_field("down_count", seen_want.down_count, out_down_count);
        check_field("up_count", seen_want.up_count, out_up_count);
        check_field("total_count", seen_want.total_count, out_total_count);
      end
    end
  end

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_item(input blob_item_t it, input bit typed, input track_result_t want);
    track_result_t pred;
    int gap;
    start <= 1'b1;
    in_has_blob <= it.has_blob;
    in_box_x <= it.box_x;
    in_box_y <= it.box_y;
    in_box_w <= it.box_w;
    in_box_h <= it.box_h;
    in_blob_area <= it.area;
    in_frame_end <= it.frame_end;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = predict_track(it);
    pending_results.push_back(typed ? want : pred);
    if (pred.accepted || pred.table_full || pred.frame_done) n_counted++;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle(input int extra);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // APB write, then read back through the same port
  task automatic set_reg(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] mask, wdata, got;
    case (idx)
      REG_MIN_AREA:  mask = (32'd1 << AREA_BITS) - 32'd1;
      REG_RADIUS_SQ: mask = (32'd1 << RADIUS_BITS) - 32'd1;
      default:       mask = (32'd1 << LINE_BITS) - 32'd1;
    endcase
    wdata = (val & mask) | ($urandom & ~mask);
    case (idx)
      REG_MIN_AREA:  track_cfg.min_area = wdata[AREA_BITS-1:0];
      REG_RADIUS_SQ: track_cfg.radius_sq = wdata[RADIUS_BITS-1:0];
      REG_DOWN_LINE: track_cfg.down_line = wdata[LINE_BITS-1:0];
      default:       track_cfg.up_line = wdata[LINE_BITS-1:0];
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    check_field("register readback", wdata & mask, got);
    @(posedge clk);
  endtask

  function automatic blob_item_t noise_item(input bit pass_area);
    blob_item_t it;
    it.has_blob = pass_area ? 1'b1 : ($urandom_range(9) < 7);
    it.box_x = BOX_BITS'($urandom);
    it.box_y = BOX_BITS'($urandom);
    it.box_w = BOX_BITS'($urandom);
    it.box_h = BOX_BITS'($urandom);
    it.frame_end = 1'b0;
    if (pass_area) begin
      it.area = AREA_BITS'($urandom_range(AREA_MAX, track_cfg.min_area));
    end else begin
      case ($urandom_range(3))
        0: it.area = AREA_BITS'($urandom);
        1: it.area = track_cfg.min_area;
        2: it.area = track_cfg.min_area - 1'b1;
        default: it.area = AREA_BITS'($urandom_range(AREA_MAX, track_cfg.min_area));
      endcase
    end
    return it;
  endfunction

  function automatic void spawn_car(input int k);
    int line, off;
    car_down[k] = $urandom_range(1);
    line = car_down[k] ? int'(track_cfg.down_line) : int'(track_cfg.up_line);
    off = $urandom_range(300, 40);
    car_v[k] = $urandom_range(60, 10);
    if (car_down[k]) begin
      car_cy[k] = line - off;
    end else begin
      car_cy[k] = line + off;
      car_v[k] = -car_v[k];
    end
    if (car_cy[k] < 0) car_cy[k] = 0;
    if (car_cy[k] > 12000) car_cy[k] = 12000;
    car_cx[k] = 400 + 700 * k;
  endfunction

  function automatic blob_item_t car_item(input int k);
    blob_item_t it;
    int w, h, y;
    w = $urandom_range(100, 16);
    h = $urandom_range(100, 16);
    y = (car_cy[k] >= h) ? (car_cy[k] - h) / 2 : 0;
    if (y > 4095) y = 4095;
    it.has_blob = 1'b1;
    it.box_x = BOX_BITS'((car_cx[k] - w) / 2);
    it.box_y = BOX_BITS'(y);
    it.box_w = BOX_BITS'(w);
    it.box_h = BOX_BITS'(h);
    it.area = AREA_BITS'($urandom_range(AREA_MAX, track_cfg.min_area));
    it.frame_end = 1'b0;
    return it;
  endfunction

  task automatic run_frame();
    blob_item_t fq [$];
    blob_item_t tmp;
    int kind, j, line;
    kind = $urandom_range(99);
    // flood frames overflow the table
    if (kind < 4) repeat ($urandom_range(40, 34)) fq.push_back(noise_item(1'b1));
    if (kind >= 4 && kind < 8) begin
      tmp = noise_item(1'b0);
      tmp.has_blob = 1'b0;
      fq.push_back(tmp);
    end else begin
      for (int k = 0; k < n_cars; k++)
        if ($urandom_range(9) != 0) fq.push_back(car_item(k));
      repeat ($urandom_range(2)) fq.push_back(noise_item(1'b0));
    end
    for (int i = fq.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = fq[i];
      fq[i] = fq[j];
      fq[j] = tmp;
    end
    if (fq.size() == 0 || $urandom_range(1)) fq.push_back(noise_item(1'b0));
    tmp = fq.pop_back();
    tmp.frame_end = 1'b1;
    fq.push_back(tmp);
    foreach (fq[i]) send_item(fq[i], 1'b0, '0);
    for (int k = 0; k < n_cars; k++) begin
      car_cy[k] += car_v[k];
      line = car_down[k] ? int'(track_cfg.down_line) : int'(track_cfg.up_line);
      if (car_cy[k] < 0 || car_cy[k] > 12000 || $urandom_range(99) < 3 ||
          (car_down[k] && car_cy[k] > line + 300) ||
          (!car_down[k] && car_cy[k] < line - 300))
        spawn_car(k);
    end
  endtask

  initial begin
    cfg_t pc;
    int budget;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_tab[i])
      send_item(directed_tab[i].item, directed_tab[i].typed, directed_tab[i].want);
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        wait_idle(8);
        case (ph)
          1: pc = '{24'd0, 26'd19600, 13'd1120, 13'd1140};
          2: pc = '{24'hFFFFFF, 26'd0, 13'd0, 13'h1FFF};
          3: pc = '{24'd300, 26'h3FFFFFF, 13'h1FFF, 13'd0};
          5: pc = '{24'd1000, 26'd10000, 13'd2000, 13'd2030};
          default: begin
            pc.min_area = AREA_BITS'($urandom_range(2000));
            pc.radius_sq = RADIUS_BITS'($urandom_range(40000, 2000));
            pc.down_line = LINE_BITS'($urandom_range(8000, 200));
            pc.up_line = pc.down_line + LINE_BITS'($urandom_range(60)) - 13'd30;
          end
        endcase
        set_reg(REG_MIN_AREA, 32'(pc.min_area));
        set_reg(REG_RADIUS_SQ, 32'(pc.radius_sq));
        set_reg(REG_DOWN_LINE, 32'(pc.down_line));
        set_reg(REG_UP_LINE, 32'(pc.up_line));
      end
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 85;
        default: idle_pct = 10;
      endcase
      budget = (ph == 2) ? 120 : 220;
      n_cars = $urandom_range(MAX_CARS, 1);
      for (int k = 0; k < n_cars; k++) spawn_car(k);
      n_counted = 0;
      while (n_counted < budget) begin
        if ($urandom_range(99) == 0) wait_idle(2);
        run_frame();
      end
    end
    wait_idle(120);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(8 * 1000000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
